>>> rtl/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_W  = 64;
	localparam int LEN_W  = 4;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES,
		REG_PATTERN_LEN,
		REG_REPLACE_BYTES,
		REG_REPLACE_LEN
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPL,
		ST_FLUSH
	} ssr_state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic repl_start;
		logic repl_step;
		logic emit;
		logic emit_final;
	} dp_cmd_t;

	typedef struct packed {
		logic pass;
		logic full_match;
		logic partial;
		logic shift_prefix;
		logic one_left;
		logic empty;
		logic repl_last;
		logic last_q;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/ssr_in_if.sv
`default_nettype none

interface ssr_in_if;
	import ssr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

>>> rtl/ssr_out_if.sv
`default_nettype none

interface ssr_out_if;
	import ssr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_end;
	logic              text_end;

	modport source(output valid, output out_byte, output run_end, output text_end,
		input ready);
	modport sink(input valid, input out_byte, input run_end, input text_end,
		output ready);
endinterface

`default_nettype wire

>>> rtl/ssr_ctrl.sv
`default_nettype none

module ssr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ssr_pkg::dp_stat_t stat,
	output ssr_pkg::dp_cmd_t       cmd
);
	import ssr_pkg::*;

	ssr_state_t state_q;
	ssr_state_t state_d;
	logic       accept;
	logic       rel_final;

	assign accept    = in_valid && in_ready;
	assign rel_final = stat.shift_prefix && (!stat.last_q || stat.one_left);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = stat.pass ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.full_match) begin
					state_d = ST_REPL;
				end else if (stat.partial) begin
					state_d = (stat.last_q && !stat.empty) ? ST_FLUSH : ST_IDLE;
				end else if (stat.out_free && rel_final) begin
					state_d = ST_IDLE;
				end
			end
			ST_REPL: begin
				if (stat.out_free && stat.repl_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free && stat.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = accept;
			end
			ST_SCAN: begin
				if (stat.full_match) begin
					cmd.repl_start = 1'b1;
				end else if (!stat.partial && stat.out_free) begin
					cmd.shift      = 1'b1;
					cmd.emit       = 1'b1;
					cmd.emit_final = rel_final;
				end
			end
			ST_REPL: begin
				if (stat.out_free) begin
					cmd.repl_step  = 1'b1;
					cmd.emit       = 1'b1;
					cmd.emit_final = stat.repl_last;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					cmd.shift      = 1'b1;
					cmd.emit       = 1'b1;
					cmd.emit_final = stat.one_left;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_repl_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REPL |-> stat.empty)
		else $error("replacement in progress while bytes are pending");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> !stat.empty)
		else $error("flush entered with nothing pending");
`endif

endmodule

`default_nettype wire

>>> rtl/ssr_datapath.sv
`default_nettype none

module ssr_datapath #(
	parameter int MAX_PATTERN = 8,
	parameter int MAX_REPLACE = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [ssr_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic [ssr_pkg::BYTE_W-1:0] in_byte,
	input  wire logic                       in_last,
	input  wire ssr_pkg::dp_cmd_t           cmd,
	output ssr_pkg::dp_stat_t               stat,
	ssr_out_if.source                       result
);
	import ssr_pkg::*;

	localparam int CW  = $clog2(MAX_PATTERN + 1);
	localparam int RCW = $clog2(MAX_REPLACE + 1);
	localparam int RIW = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

	logic [CFG_W-1:0]  pattern_q;
	logic [LEN_W-1:0]  pattern_len_q;
	logic [CFG_W-1:0]  replace_q;
	logic [LEN_W-1:0]  replace_len_q;

	logic [BYTE_W-1:0] pend_q [MAX_PATTERN];
	logic [CW-1:0]     cnt_q;
	logic              last_q;
	logic [RIW-1:0]    rcnt_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              run_end_q;
	logic              text_end_q;

	logic [CW-1:0]     plen;
	logic [RCW-1:0]    rlen;
	logic              is_prefix;
	logic              shift_prefix;
	logic [BYTE_W-1:0] rep_byte;
	logic [BYTE_W-1:0] emit_byte;
	logic              pat_clear;

	assign plen = (pattern_len_q > LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
		: pattern_len_q[CW-1:0];
	assign rlen = (replace_len_q > LEN_W'(MAX_REPLACE)) ? RCW'(MAX_REPLACE)
		: replace_len_q[RCW-1:0];

	always_comb begin
		is_prefix    = 1'b1;
		shift_prefix = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((CW'(i) < cnt_q) && (pend_q[i] != pattern_q[BYTE_W*i +: BYTE_W])) begin
				is_prefix = 1'b0;
			end
			if (i < MAX_PATTERN - 1) begin
				if ((CW'(i + 1) < cnt_q)
						&& (pend_q[i + 1] != pattern_q[BYTE_W*i +: BYTE_W])) begin
					shift_prefix = 1'b0;
				end
			end
		end
	end

	assign rep_byte  = replace_q[{rcnt_q, 3'b000} +: BYTE_W];
	assign emit_byte = cmd.repl_step ? rep_byte : pend_q[0];

	assign stat.pass         = (plen == '0) || (rlen == '0);
	assign stat.full_match   = (cnt_q == plen) && is_prefix;
	assign stat.partial      = (cnt_q < plen) && is_prefix;
	assign stat.shift_prefix = shift_prefix;
	assign stat.one_left     = (cnt_q == CW'(1));
	assign stat.empty        = (cnt_q == '0);
	assign stat.repl_last    = ((RCW'(rcnt_q) + RCW'(1)) == rlen);
	assign stat.last_q       = last_q;
	assign stat.out_free     = !out_valid_q || result.ready;

	assign pat_clear = cfg_we && ((cfg_index == REG_PATTERN_BYTES)
		|| (cfg_index == REG_PATTERN_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			pattern_len_q <= '0;
			replace_q     <= '0;
			replace_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_BYTES: pattern_q     <= cfg_data;
				REG_PATTERN_LEN:   pattern_len_q <= cfg_data[LEN_W-1:0];
				REG_REPLACE_BYTES: replace_q     <= cfg_data;
				REG_REPLACE_LEN:   replace_len_q <= cfg_data[LEN_W-1:0];
				default:           pattern_q     <= pattern_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rcnt_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pat_clear || cmd.repl_start) begin
				cnt_q <= '0;
			end else if (cmd.load) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.shift) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.load) begin
				last_q <= in_last;
			end
			if (cmd.repl_start) begin
				rcnt_q <= '0;
			end else if (cmd.repl_step) begin
				rcnt_q <= rcnt_q + RIW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (cmd.load && (cnt_q == CW'(i))) begin
				pend_q[i] <= in_byte;
			end else if (cmd.shift && (i < MAX_PATTERN - 1)) begin
				pend_q[i] <= pend_q[i + 1];
			end
		end
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			run_end_q  <= cmd.emit_final;
			text_end_q <= cmd.emit_final && last_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.run_end  = run_end_q;
	assign result.text_end = text_end_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || result.ready))
		else $error("result register overwritten before it was taken");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (cnt_q < CW'(MAX_PATTERN)))
		else $error("pending buffer overflow");

	a_text_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_final && last_q) |=> (cnt_q == '0))
		else $error("bytes left pending after the end of the text");
`endif

endmodule

`default_nettype wire

>>> rtl/stream_substring_replace.sv
`default_nettype none

// Streaming find-and-replace: text bytes enter one per transaction on the text
// channel, and every leftmost, non-overlapping occurrence of the pattern is
// replaced on the result channel, one byte per transaction, with run_end on the
// last byte an input caused and text_end on the final byte of the text. A byte
// that only extends a partial match yields no result. Otherwise the result
// bytes of an item leave through the single result register, one byte per
// cycle while the result channel is ready; a full match drops the pending
// bytes before the replacement starts, and a partial match at the end of the
// text is flushed out as it stands. Input is taken only between items, while
// the last result of the previous item may still wait in the result register.
// Pattern and replacement lengths above MAX_PATTERN and MAX_REPLACE saturate,
// a zero length makes the block pass the text through, and writing a pattern
// register discards pending bytes.
module stream_substring_replace #(
	parameter int MAX_PATTERN = 8,
	parameter int MAX_REPLACE = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [ssr_pkg::CFG_W-1:0] cfg_data,
	ssr_in_if.sink                         text,
	ssr_out_if.source                      result
);
	import ssr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ready;

	assign text.ready = ready;

	ssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssr_datapath #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_REPLACE (MAX_REPLACE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (text.in_byte),
		.in_last   (text.in_last),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

`default_nettype wire

>>> tb/stream_substring_replace_test.sv
module stream_substring_replace_test;
	import ssr_pkg::*;

	localparam int MAX_PAT = 8;
	localparam int MAX_REP = 8;
	localparam int PHASES = 10;
	localparam int PLEN_TAB [PHASES] = '{1, 8, 2, 3, 9, 4, 0, 5, 8, 6};
	localparam int RLEN_TAB [PHASES] = '{8, 1, 3, 0, 2, 8, 5, 12, 1, 4};

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} text_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              run_end;
		logic              text_end;
	} out_item_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ssr_in_if  text_if();
	ssr_out_if result_if();

	stream_substring_replace DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text(text_if),
		.result(result_if)
	);

	always #1 clk = ~clk;

	text_item_t text_q[$];
	out_item_t  rewritten_q[$];
	text_item_t drv_item;
	int         sent_n = 0;
	int         taken_n = 0;
	int         errors = 0;
	int         gap = 0;
	int         stall = 0;
	bit         quiet = 1'b0;

	// Shadow copy of the registers and of the bytes held back as a partial match.
	logic [CFG_W-1:0]  pat_word = '0;
	logic [CFG_W-1:0]  rep_word = '0;
	logic [LEN_W-1:0]  pat_len = '0;
	logic [LEN_W-1:0]  rep_len = '0;
	logic [BYTE_W-1:0] pending [MAX_PAT];
	int                pend_n = 0;

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic bit pending_is_prefix();
		for (int i = 0; i < pend_n; i++)
			if (pending[i] != pat_word[8*i +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic emit_byte(input logic [BYTE_W-1:0] d);
		out_item_t o;
		o.data = d;
		o.run_end = 1'b0;
		o.text_end = 1'b0;
		rewritten_q.push_back(o);
	endtask

	task automatic release_pending();
		for (int i = 0; i < pend_n; i++)
			emit_byte(pending[i]);
		pend_n = 0;
	endtask

	task automatic rewrite_text_byte(input text_item_t it);
		int plen;
		int rlen;
		int n0;
		bit settled;
		plen = (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
		rlen = (rep_len > MAX_REP) ? MAX_REP : rep_len;
		n0 = rewritten_q.size();
		if (plen == 0 || rlen == 0) begin
			release_pending();
			emit_byte(it.data);
		end else begin
			if (pend_n >= plen)
				release_pending();
			pending[pend_n] = it.data;
			pend_n++;
			settled = 1'b0;
			while (pend_n > 0 && !settled) begin
				if (pend_n == plen && pending_is_prefix()) begin
					for (int i = 0; i < rlen; i++)
						emit_byte(rep_word[8*i +: 8]);
					pend_n = 0;
				end else if (pend_n < plen && pending_is_prefix()) begin
					settled = 1'b1;
				end else begin
					emit_byte(pending[0]);
					for (int i = 0; i < MAX_PAT - 1; i++)
						pending[i] = pending[i+1];
					pend_n--;
				end
			end
		end
		if (it.last)
			release_pending();
		if (rewritten_q.size() > n0) begin
			rewritten_q[rewritten_q.size()-1].run_end = 1'b1;
			rewritten_q[rewritten_q.size()-1].text_end = it.last;
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PATTERN_BYTES: begin
				pat_word = value;
				pend_n = 0;
			end
			REG_PATTERN_LEN: begin
				pat_len = value[LEN_W-1:0];
				pend_n = 0;
			end
			REG_REPLACE_BYTES: rep_word = value;
			REG_REPLACE_LEN: rep_len = value[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send(input logic [BYTE_W-1:0] d, input logic l);
		text_item_t it;
		it.data = d;
		it.last = l;
		text_q.push_back(it);
		sent_n++;
	endtask

	task automatic send_str(input string s, input bit end_text);
		for (int i = 0; i < s.len(); i++)
			send(s[i], end_text && i == s.len() - 1);
	endtask

	// Mostly whole or partial copies of the pattern, with some noise between them.
	task automatic fill_text(input int n, input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
		int pl;
		int cnt;
		int r;
		int k;
		logic [BYTE_W-1:0] d;
		pl = (pat_len == 0) ? 3 : ((pat_len > MAX_PAT) ? MAX_PAT : pat_len);
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				k = pl;
			else if (r < 7)
				k = $urandom_range(1, pl);
			else
				k = $urandom_range(1, 3);
			for (int i = 0; i < k; i++) begin
				if (r < 7)
					d = pat_word[8*i +: 8];
				else if (r < 9)
					d = $urandom_range(0, 1) ? a : b;
				else
					d = BYTE_W'($urandom_range(0, 255));
				send(d, $urandom_range(0, 15) == 0);
				cnt++;
			end
		end
	endtask

	task automatic settle();
		while (taken_n != sent_n || rewritten_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(5, 24);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			text_if.in_byte <= '0;
			text_if.in_last <= 1'b0;
			gap <= 0;
		end else begin
			if (text_if.valid && text_if.ready) begin
				rewrite_text_byte(drv_item);
				taken_n++;
			end
			if (!text_if.valid || text_if.ready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					text_if.valid <= 1'b0;
				end else if (text_q.size() > 0) begin
					drv_item = text_q.pop_front();
					text_if.valid <= 1'b1;
					text_if.in_byte <= drv_item.data;
					text_if.in_last <= drv_item.last;
					if (!quiet && $urandom_range(0, 3) == 0)
						gap <= idle_len();
				end else begin
					text_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t want;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall <= 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (rewritten_q.size() == 0) begin
					report($sformatf("unexpected transaction, byte %h", result_if.out_byte));
				end else begin
					want = rewritten_q.pop_front();
					if (result_if.out_byte !== want.data || result_if.run_end !== want.run_end
							|| result_if.text_end !== want.text_end)
						report($sformatf("got byte %h run_end %b text_end %b, want %h %b %b",
							result_if.out_byte, result_if.run_end, result_if.text_end,
							want.data, want.run_end, want.text_end));
				end
			end
			if (stall > 0) begin
				stall <= stall - 1;
				result_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall <= idle_len() - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
		logic [CFG_W-1:0]  w;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Registers are still zero after reset, so the text passes through.
		send(8'h00, 1'b0);
		send(8'hff, 1'b1);
		settle();

		write_reg(REG_PATTERN_BYTES, 64'h636261);
		write_reg(REG_PATTERN_LEN, 3);
		write_reg(REG_REPLACE_BYTES, 64'h5958);
		write_reg(REG_REPLACE_LEN, 2);
		send_str("aabcabxab", 1'b1);
		settle();

		// Held bytes must survive a replacement write and leave on pass-through.
		send_str("ab", 1'b0);
		settle();
		write_reg(REG_REPLACE_LEN, 0);
		send_str("c", 1'b1);
		settle();

		write_reg(REG_PATTERN_BYTES, '1);
		write_reg(REG_PATTERN_LEN, 15);
		write_reg(REG_REPLACE_BYTES, '0);
		write_reg(REG_REPLACE_LEN, 15);
		repeat (9) send(8'hff, 1'b0);
		send(8'h00, 1'b1);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			quiet = (p == 2 || p == 6);
			a = BYTE_W'($urandom_range(0, 255));
			b = BYTE_W'($urandom_range(0, 255));
			if (p == 3) begin
				a = 8'h00;
				b = 8'hff;
			end
			for (int k = 0; k < 8; k++)
				w[8*k +: 8] = $urandom_range(0, 1) ? a : b;
			write_reg(REG_PATTERN_BYTES, w);
			write_reg(REG_PATTERN_LEN, CFG_W'(PLEN_TAB[p]));
			write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
			write_reg(REG_REPLACE_LEN, CFG_W'(RLEN_TAB[p]));
			fill_text(11, a, b);
			settle();
			if (p % 2 == 1) begin
				write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
				write_reg(REG_REPLACE_LEN, CFG_W'($urandom_range(1, 8)));
			end
			fill_text(11, a, b);
			settle();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ssr_pkg.sv
rtl/ssr_in_if.sv
rtl/ssr_out_if.sv
rtl/ssr_ctrl.sv
rtl/ssr_datapath.sv
rtl/stream_substring_replace.sv
tb/stream_substring_replace_test.sv
